// File: hw/rtl/bbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared constants, types and helper functions of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned HeightLimit = 4096;

  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned OutRowW = $clog2(HeightLimit);
  localparam int unsigned InRowW  = OutRowW + 1;

  localparam int unsigned FwW      = 11;
  localparam int unsigned FhW      = 13;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;

  localparam int unsigned ChW  = 8;
  localparam int unsigned PixW = 3 * ChW;
  localparam int unsigned LsW  = 2 * PixW;
  localparam int unsigned SumW = 12;

  // Division by nine as a multiply by a reciprocal: exact for sums below 3276.
  localparam int unsigned DivMul   = 1821;
  localparam int unsigned DivShift = 14;
  localparam int unsigned ProdW    = SumW + 11;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [ChW-1:0] AlphaOpaque = 8'hFF;

  typedef logic [ColW:0]     width_t;
  typedef logic [InRowW-1:0] height_t;

  localparam width_t  WidthReset  = width_t'(800);
  localparam height_t HeightReset = height_t'(600);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  // Which neighbors of the output pixel lie inside the frame.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } nbr_mask_t;

  // One request handed from the sequencer to the filter datapath.
  typedef struct packed {
    logic            valid;
    logic            emit;
    logic            last;
    nbr_mask_t       mask;
    logic [ColW-1:0] ix;
    logic [PixW-1:0] pix;
  } item_req_t;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic           last;
  } out_item_t;

  function automatic width_t clamp_width(logic [FwW-1:0] raw);
    width_t res;
    if (raw == '0) begin
      res = width_t'(1);
    end else if (32'(raw) > MaxWidth) begin
      res = width_t'(MaxWidth);
    end else begin
      res = width_t'(raw);
    end
    return res;
  endfunction

  function automatic height_t clamp_height(logic [FhW-1:0] raw);
    height_t res;
    if (raw == '0) begin
      res = height_t'(1);
    end else if (32'(raw) > HeightLimit) begin
      res = height_t'(HeightLimit);
    end else begin
      res = height_t'(raw);
    end
    return res;
  endfunction

  function automatic logic [ChW-1:0] div9(logic [SumW-1:0] sum);
    logic [ProdW-1:0] prod;
    prod = ProdW'(sum) * ProdW'(DivMul);
    return prod[DivShift +: ChW];
  endfunction

endpackage

// File: hw/rtl/bbr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bbr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_seq
// Frame geometry registers and the input and output position counters.
// ----------------------------------------------------------------------------
module bbr_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         opcode_i,
  input  logic [bbr_pkg::ChW-1:0]      in_red_i,
  input  logic [bbr_pkg::ChW-1:0]      in_green_i,
  input  logic [bbr_pkg::ChW-1:0]      in_blue_i,
  input  logic                         cfg_we_i,
  input  logic [bbr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bbr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bbr_pkg::item_req_t           req_o
);

  bbr_pkg::width_t  width_q, width_d;
  bbr_pkg::height_t height_q, height_d;

  logic [bbr_pkg::ColW-1:0]    in_col_q, in_col_d;
  logic [bbr_pkg::InRowW-1:0]  in_row_q, in_row_d;
  logic [bbr_pkg::ColW-1:0]    out_col_q, out_col_d;
  logic [bbr_pkg::OutRowW-1:0] out_row_q, out_row_d;

  logic            accept;
  logic            in_frame;
  logic            take;
  logic            emit;
  logic            last;
  logic            col_wrap;
  logic            out_col_wrap;
  bbr_pkg::width_t in_col_inc;
  bbr_pkg::width_t out_col_inc;
  bbr_pkg::height_t out_row_inc;

  assign accept   = in_valid_i && !in_stall_i;
  assign in_frame = in_row_q < height_q;
  // Once every line has arrived, any item drains the frame with zero data.
  assign take     = in_frame ? (opcode_i == bbr_pkg::OP_PIXEL) : 1'b1;

  // An output is due once a full line plus one pixel has been taken.
  assign emit = (in_row_q > bbr_pkg::InRowW'(1)) ||
                ((in_row_q == bbr_pkg::InRowW'(1)) && (in_col_q != '0));

  assign in_col_inc   = {1'b0, in_col_q} + bbr_pkg::width_t'(1);
  assign out_col_inc  = {1'b0, out_col_q} + bbr_pkg::width_t'(1);
  assign out_row_inc  = {1'b0, out_row_q} + bbr_pkg::height_t'(1);
  assign col_wrap     = in_col_inc >= width_q;
  assign out_col_wrap = out_col_inc >= width_q;
  assign last         = emit && (out_col_inc == width_q) && (out_row_inc == height_q);

  always_comb begin
    req_o.valid       = accept && take;
    req_o.emit        = emit;
    req_o.last        = last;
    req_o.mask.top    = out_row_q != '0;
    req_o.mask.bottom = out_row_inc < height_q;
    req_o.mask.left   = out_col_q != '0;
    req_o.mask.right  = out_col_inc < width_q;
    req_o.ix          = in_col_q;
    req_o.pix         = in_frame ? {in_red_i, in_green_i, in_blue_i} : '0;
  end

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i) begin
      unique case (bbr_pkg::cfg_reg_e'(cfg_idx_i))
        bbr_pkg::REG_FRAME_WIDTH: begin
          width_d = bbr_pkg::clamp_width(cfg_wdata_i[bbr_pkg::FwW-1:0]);
        end
        bbr_pkg::REG_FRAME_HEIGHT: begin
          height_d = bbr_pkg::clamp_height(cfg_wdata_i[bbr_pkg::FhW-1:0]);
        end
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept && take) begin
      if (col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + bbr_pkg::InRowW'(1);
      end else begin
        in_col_d = in_col_inc[bbr_pkg::ColW-1:0];
      end
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (emit) begin
        if (out_col_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_inc[bbr_pkg::OutRowW-1:0];
        end else begin
          out_col_d = out_col_inc[bbr_pkg::ColW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= bbr_pkg::WidthReset;
      height_q  <= bbr_pkg::HeightReset;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// File: hw/rtl/bbr_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_filter
// Line store read-modify-write, 3x3 window, masked sums and divide by nine.
// ----------------------------------------------------------------------------
module bbr_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbr_pkg::item_req_t req_i,
  input  logic               clear_i,
  output logic               push_o,
  output bbr_pkg::out_item_t push_data_o,
  output logic [1:0]         pending_o
);

  // Each line store entry holds {line above, line two above}.
  logic [bbr_pkg::LsW-1:0]  ram_rdata;
  logic [bbr_pkg::LsW-1:0]  ram_wdata;
  logic [bbr_pkg::LsW-1:0]  word;
  logic [bbr_pkg::LsW-1:0]  wr_data_q;
  logic [bbr_pkg::PixW-1:0] above;
  logic [bbr_pkg::PixW-1:0] above2;

  bbr_pkg::item_req_t s1_q;
  logic               fwd_q;

  logic [bbr_pkg::PixW-1:0] win_q [3][3];
  logic [bbr_pkg::PixW-1:0] win_n [3][3];
  logic                     row_ok [3];
  logic                     col_ok [3];
  logic [bbr_pkg::SumW-1:0] sum_d  [3];
  logic [bbr_pkg::SumW-1:0] sum_q  [3];
  logic                     s2_vld_q;
  logic                     s2_last_q;

  bbr_ram #(
    .Width(bbr_pkg::LsW),
    .Depth(bbr_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_q.valid),
    .waddr_i(s1_q.ix),
    .wdata_i(ram_wdata),
    .re_i   (req_i.valid),
    .raddr_i(req_i.ix),
    .rdata_o(ram_rdata)
  );

  // With a one-pixel line, the next request reads the entry being written now.
  assign word      = fwd_q ? wr_data_q : ram_rdata;
  assign above     = word[bbr_pkg::LsW-1:bbr_pkg::PixW];
  assign above2    = word[bbr_pkg::PixW-1:0];
  assign ram_wdata = {s1_q.pix, above};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_n[r][0] = win_q[r][1];
      win_n[r][1] = win_q[r][2];
    end
    win_n[0][2] = above2;
    win_n[1][2] = above;
    win_n[2][2] = s1_q.pix;

    row_ok[0] = s1_q.mask.top;
    row_ok[1] = 1'b1;
    row_ok[2] = s1_q.mask.bottom;
    col_ok[0] = s1_q.mask.left;
    col_ok[1] = 1'b1;
    col_ok[2] = s1_q.mask.right;

    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            sum_d[ch] = sum_d[ch] + bbr_pkg::SumW'(
                win_n[r][c][bbr_pkg::PixW-1-bbr_pkg::ChW*ch -: bbr_pkg::ChW]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      fwd_q     <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      s1_q      <= req_i;
      fwd_q     <= req_i.valid && s1_q.valid && (req_i.ix == s1_q.ix);
      s2_vld_q  <= s1_q.valid && s1_q.emit;
      s2_last_q <= s1_q.last;
      if (clear_i || (s1_q.valid && s1_q.last)) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win_q[r][c] <= '0;
          end
        end
      end else if (s1_q.valid) begin
        win_q <= win_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      wr_data_q <= ram_wdata;
    end
    sum_q <= sum_d;
  end

  assign push_o            = s2_vld_q;
  assign push_data_o.red   = bbr_pkg::div9(sum_q[0]);
  assign push_data_o.green = bbr_pkg::div9(sum_q[1]);
  assign push_data_o.blue  = bbr_pkg::div9(sum_q[2]);
  assign push_data_o.last  = s2_last_q;
  assign pending_o         = 2'(s1_q.valid && s1_q.emit) + 2'(s2_vld_q);

  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> $past(s1_q.valid && s1_q.emit))
    else $error("sum stage loaded without an emitting window stage");

  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (s1_q.valid && $past(s1_q.valid)))
    else $error("line store forwarding without a preceding write");

endmodule

// File: hw/rtl/bbr_ofifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_ofifo
// Output queue; holds back new requests while results in flight could fill it.
// ----------------------------------------------------------------------------
module bbr_ofifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bbr_pkg::out_item_t push_data_i,
  input  logic [1:0]         pending_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bbr_pkg::out_item_t out_data_o
);

  bbr_pkg::out_item_t mem_q [bbr_pkg::FifoDepth];

  logic [bbr_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [bbr_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic [bbr_pkg::FifoCntW:0]   reserved;
  logic                         pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];

  // Every result already in flight owns a slot before a new request is taken.
  assign reserved   = {1'b0, cnt_q} + (bbr_pkg::FifoCntW + 1)'(pending_i);
  assign in_stall_o = reserved >= (bbr_pkg::FifoCntW + 1)'(bbr_pkg::FifoDepth);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + bbr_pkg::FifoCntW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - bbr_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + bbr_pkg::FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + bbr_pkg::FifoPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < bbr_pkg::FifoCntW'(bbr_pkg::FifoDepth)))
    else $error("output queue written while full");

endmodule

// File: hw/rtl/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// Path: a result passes the window stage, the sum stage and the output queue after
//   the request that completes its neighborhood, one line plus one pixel later.
// Throughput: one request per cycle when not stalled, set by the single line store
//   RAM doing one read and one write per cycle; a four-entry queue absorbs output stalls.
// Reset: width 800, height 600, counters and window cleared; the line store is
//   not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur over a raster RGB pixel stream with zero-padded borders.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [bbr_pkg::ChW-1:0]      in_red_i,
  input  logic [bbr_pkg::ChW-1:0]      in_green_i,
  input  logic [bbr_pkg::ChW-1:0]      in_blue_i,
  input  logic                         cfg_we_i,
  input  logic [bbr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bbr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bbr_pkg::ChW-1:0]      out_red_o,
  output logic [bbr_pkg::ChW-1:0]      out_green_o,
  output logic [bbr_pkg::ChW-1:0]      out_blue_o,
  output logic [bbr_pkg::ChW-1:0]      out_alpha_o,
  output logic                         frame_last_o
);

  bbr_pkg::item_req_t req;
  bbr_pkg::out_item_t push_data;
  bbr_pkg::out_item_t out_data;
  logic               push;
  logic [1:0]         pending;

  bbr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .opcode_i   (opcode_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_o      (req)
  );

  bbr_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .clear_i    (cfg_we_i),
    .push_o     (push),
    .push_data_o(push_data),
    .pending_o  (pending)
  );

  bbr_ofifo u_ofifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pending_i  (pending),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign out_red_o    = out_data.red;
  assign out_green_o  = out_data.green;
  assign out_blue_o   = out_data.blue;
  assign out_alpha_o  = bbr_pkg::AlphaOpaque;
  assign frame_last_o = out_data.last;

endmodule
